// File: rtl/ple_pkg.sv
// ple_pkg: shared types and codes for the positional list engine
// request and response payload structs, opcode, status, state and cell action codes
// no dependencies
`default_nettype none

package ple_pkg;

	// request opcodes
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_DUMP      = 3'd6,
		OP_DUMP_REV  = 3'd7
	} op_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	// per-cycle action broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROTL,
		CELL_ROTR
	} cell_op_t;

	// request payload
	typedef struct packed {
		op_t                opcode;
		logic signed [31:0] value;
		logic [7:0]         position;
	} req_t;

	// response payload
	typedef struct packed {
		status_t            status;
		logic signed [31:0] item;
		logic               last;
		logic [4:0]         count;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/ple_cell.sv
// ple_cell: one list slot of the cell chain, holds a single element
// moves data from its left or right neighbor, loads a new value, or wraps during dumps
// depends on ple_pkg
`default_nettype none

module ple_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  wire                          clk,
	input  ple_pkg::cell_op_t            action,
	input  wire [$clog2(DEPTH+1)-1:0]    idx,
	input  wire [$clog2(DEPTH+1)-1:0]    cnt,
	input  wire signed [31:0]            value,
	input  wire signed [31:0]            left,
	input  wire signed [31:0]            right,
	input  wire signed [31:0]            head,
	output logic signed [31:0]           data
);
	import ple_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] MY  = CW'(INDEX);
	localparam logic [CW-1:0] MY1 = CW'(INDEX + 1);

	logic signed [31:0] data_q;
	logic signed [31:0] data_n;

	// next element value for this slot
	always_comb begin
		data_n = data_q;
		unique case (action)
			CELL_INS: begin
				if (MY == idx) begin
					data_n = value;
				end else if (MY > idx && MY <= cnt) begin
					data_n = left;
				end
			end
			CELL_DEL: begin
				if (MY >= idx && MY1 < cnt) begin
					data_n = right;
				end
			end
			CELL_ROTL: begin
				if (MY1 == cnt) begin
					data_n = head;
				end else if (MY1 < cnt) begin
					data_n = right;
				end
			end
			CELL_ROTR: begin
				if (MY < cnt) begin
					data_n = left;
				end
			end
			default: data_n = data_q;
		endcase
	end

	// element storage, no reset needed
	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: rtl/positional_list_engine.sv
// positional_list_engine: ordered list of signed 32-bit values in a chain of cells
// decodes requests, drives the cell chain and holds the response register
// depends on ple_pkg and ple_cell
//
//   channel | signals                     | payload
//   req     | req_valid, req_stall, req   | opcode, value, position
//   rsp     | rsp_valid, rsp_stall, rsp   | status, item, last, count
//
// inserts, deletes and error responses load the response register on acceptance: every cell shifts at once
// a dump stalls requests from its acceptance until its last element has been sent,
// one rotation of the chain per response
// the rotation restores the list order when the dump finishes
// arst_n clears the count and control state; cell contents are not reset
// rsp_stall holds the response register and pauses a running dump
`default_nettype none

module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  ple_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output ple_pkg::rsp_t  rsp
);
	import ple_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	state_t state_q, state_n;
	logic [CW-1:0] count_q;
	logic [CW-1:0] dump_k_q;
	logic          dump_rev_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          accept;
	logic          out_free;
	logic          is_empty;
	logic          is_full;
	logic          dump_last;
	logic          load_rsp;
	logic          cnt_up;
	logic          cnt_dn;
	rsp_t          rsp_n;
	cell_op_t      act;
	logic [CW-1:0] act_idx;
	logic [CW-1:0] ins_idx;
	logic [CW-1:0] del_idx;
	logic [CW-1:0] pos_m1;
	logic [7:0]    n8;
	logic [4:0]    ext_same, ext_inc, ext_dec;
	logic [IW-1:0] tail_idx;

	logic signed [31:0] cell_data [DEPTH];
	logic signed [31:0] head, tail;

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;

	// list status
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL);
	assign dump_last = (dump_k_q == count_q - CW'(1));
	assign n8        = 8'(count_q);
	assign pos_m1    = CW'(req.position - 8'd1);

	// count as seen in the 5-bit response field
	assign ext_same = 5'(count_q);
	assign ext_inc  = 5'(count_q + CW'(1));
	assign ext_dec  = 5'(count_q - CW'(1));

	// chain ends
	assign tail_idx = IW'(count_q - CW'(1));
	assign head     = cell_data[0];
	assign tail     = cell_data[tail_idx];

	// landing index of an insert
	always_comb begin
		if (req.opcode == OP_INS_FRONT) begin
			ins_idx = '0;
		end else if (req.opcode == OP_INS_BACK) begin
			ins_idx = count_q;
		end else if (is_empty || req.position <= 8'd1) begin
			ins_idx = '0;
		end else if (req.position > n8) begin
			ins_idx = count_q;
		end else begin
			ins_idx = pos_m1;
		end
	end

	// removed index of a delete
	always_comb begin
		if (req.opcode == OP_DEL_FRONT) begin
			del_idx = '0;
		end else if (req.opcode == OP_DEL_BACK) begin
			del_idx = count_q - CW'(1);
		end else if (req.position >= n8) begin
			del_idx = count_q - CW'(1);
		end else if (req.position <= 8'd1) begin
			del_idx = '0;
		end else begin
			del_idx = pos_m1;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !is_empty &&
				    (req.opcode == OP_DUMP || req.opcode == OP_DUMP_REV)) begin
					state_n = S_DUMP;
				end
			end
			S_DUMP: begin
				if (out_free && dump_last) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// cell actions and response contents
	always_comb begin
		act      = CELL_HOLD;
		act_idx  = '0;
		load_rsp = 1'b0;
		cnt_up   = 1'b0;
		cnt_dn   = 1'b0;
		rsp_n    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_rsp    = 1'b1;
					rsp_n.last  = 1'b1;
					rsp_n.count = ext_same[4:0];
					case (req.opcode) inside
						OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
							if (is_full) begin
								rsp_n.status = ST_OVER;
							end else begin
								act          = CELL_INS;
								act_idx      = ins_idx;
								cnt_up       = 1'b1;
								rsp_n.status = ST_OK;
								rsp_n.count  = ext_inc[4:0];
							end
						end
						OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
							if (is_empty) begin
								rsp_n.status = ST_UNDER;
							end else begin
								act          = CELL_DEL;
								act_idx      = del_idx;
								cnt_dn       = 1'b1;
								rsp_n.status = ST_OK;
								rsp_n.count  = ext_dec[4:0];
							end
						end
						default: begin
							// dumps: only an empty list answers here
							if (is_empty) begin
								rsp_n.status = ST_UNDER;
							end else begin
								load_rsp = 1'b0;
							end
						end
					endcase
				end
			end
			S_DUMP: begin
				if (out_free) begin
					load_rsp     = 1'b1;
					rsp_n.status = ST_OK;
					rsp_n.item   = dump_rev_q ? tail : head;
					rsp_n.last   = dump_last;
					rsp_n.count  = ext_same[4:0];
					act          = dump_rev_q ? CELL_ROTR : CELL_ROTL;
				end
			end
			default: act = CELL_HOLD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_k_q    <= '0;
			dump_rev_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cnt_up) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dn) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				dump_k_q   <= '0;
				dump_rev_q <= (req.opcode == OP_DUMP_REV);
			end else if (state_q == S_DUMP && out_free) begin
				dump_k_q <= dump_k_q + CW'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload register
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// chain of cells; cell 0 wraps to the tail, the last cell wraps to the head
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic signed [31:0] left_d, right_d;
		if (gi == 0) begin : g_first
			assign left_d = tail;
		end else begin : g_mid_l
			assign left_d = cell_data[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_d = head;
		end else begin : g_mid_r
			assign right_d = cell_data[gi+1];
		end
		ple_cell #(
			.DEPTH (DEPTH),
			.INDEX (gi)
		) u_cell (
			.clk    (clk),
			.action (act),
			.idx    (act_idx),
			.cnt    (count_q),
			.value  (req.value),
			.left   (left_d),
			.right  (right_d),
			.head   (head),
			.data   (cell_data[gi])
		);
	end

endmodule

`default_nettype wire
